FILE: rtl/core/floor_div_mod_unit_assert.svh
// Assertion macros for the floor divide and modulo unit checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FLOOR_DIV_MOD_UNIT_ASSERT_SVH
`define FLOOR_DIV_MOD_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is high
`define FDM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("floor_div_mod_unit: implication check failed");

// Implication after a fixed number of cycles, ignored while reset is high
`define FDM_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("floor_div_mod_unit: delayed check failed");

`endif

FILE: rtl/core/fdm_pkg.sv
// Shared types and constants for the floor divide and modulo unit.
// No dependencies; all other files but the assertion header refer to it.
package fdm_pkg;

  localparam int DATA_WIDTH = 32;
  // prepare stage, one stage per quotient bit, two finishing stages
  localparam int LATENCY    = DATA_WIDTH + 3;

  localparam logic [2:0] CMD_FLOOR_DIV = 3'd0;
  localparam logic [2:0] CMD_MODULO    = 3'd1;
  localparam logic [2:0] CMD_CEIL_DIV  = 3'd2;
  localparam logic [2:0] CMD_MAXIMUM   = 3'd3;
  localparam logic [2:0] CMD_MINIMUM   = 3'd4;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]                   command;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;
  } fdm_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_value;
    logic [1:0]                   error_code;
  } fdm_out_t;

  // Sideband that rides alongside the divider data
  typedef struct packed {
    logic [2:0]            command;
    logic                  neg_a;
    logic                  neg_b;
    logic                  div_zero;
    logic [DATA_WIDTH-1:0] pass_value;
  } fdm_ctl_t;

  // Divider working set: partial remainder, dividend/quotient shifter, divisor
  typedef struct packed {
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] work;
    logic [DATA_WIDTH-1:0] divisor;
  } fdm_div_t;

endpackage

FILE: rtl/core/floor_div_mod_unit.sv
// Floor divide / modulo / ceiling divide / max / min unit, fully pipelined.
// Command transfer: operand is taken at a rising edge with start high and
//   busy low. busy is high only while rst is high; otherwise a new command
//   may be issued every cycle.
// Result transfer: result is valid for exactly one cycle while done is high;
//   the receiver takes it at the edge that ends that cycle and cannot stall it.
// Pipeline: from the accepting edge to the done cycle, a command passes
//   one prepare stage, one restoring divider stage per quotient bit, then
//   two correction stages.
// Throughput: one command per cycle; results leave in issue order.
// Every command, max and min included, runs the full pipeline, so latency
//   is the same for all commands.
// Reset: synchronous rst clears every valid bit; commands in flight are
//   dropped and no done pulse follows them.
// Divide by zero returns 0 with error 1; the most negative value divided by
//   minus one saturates to the largest value with error 2.
// Depends on fdm_pkg, fdm_prep, fdm_div_step and fdm_finish.
module floor_div_mod_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fdm_pkg::fdm_in_t  operand,
  output logic              done,
  output fdm_pkg::fdm_out_t result
);

  localparam int W = fdm_pkg::DATA_WIDTH;

  logic [W:0]        chain_valid;
  fdm_pkg::fdm_div_t chain_div [W+1];
  fdm_pkg::fdm_ctl_t chain_ctl [W+1];

  assign busy = rst;

  fdm_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (start && !busy),
    .src_item    (operand),
    .stage_valid (chain_valid[0]),
    .stage_div   (chain_div[0]),
    .stage_ctl   (chain_ctl[0])
  );

  // One divider stage per quotient bit
  for (genvar i = 0; i < W; i++) begin : g_step
    fdm_div_step u_step (
      .clk         (clk),
      .rst         (rst),
      .src_valid   (chain_valid[i]),
      .src_div     (chain_div[i]),
      .src_ctl     (chain_ctl[i]),
      .stage_valid (chain_valid[i+1]),
      .stage_div   (chain_div[i+1]),
      .stage_ctl   (chain_ctl[i+1])
    );
  end

  fdm_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .src_valid (chain_valid[W]),
    .src_div   (chain_div[W]),
    .src_ctl   (chain_ctl[W]),
    .done      (done),
    .result    (result)
  );

endmodule

FILE: rtl/core/fdm_prep.sv
// Front stage: decodes the command, takes operand magnitudes, resolves max/min.
// Depends on fdm_pkg.
module fdm_prep (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  input  fdm_pkg::fdm_in_t src_item,
  output logic             stage_valid,
  output fdm_pkg::fdm_div_t stage_div,
  output fdm_pkg::fdm_ctl_t stage_ctl
);

  localparam int W = fdm_pkg::DATA_WIDTH;

  fdm_pkg::fdm_div_t div_next;
  fdm_pkg::fdm_ctl_t ctl_next;
  logic              a_less;

  // Form magnitudes, flags and the compare result
  always_comb begin
    a_less              = src_item.operand_a < src_item.operand_b;
    ctl_next.command    = src_item.command;
    ctl_next.neg_a      = src_item.operand_a[W-1];
    ctl_next.neg_b      = src_item.operand_b[W-1];
    ctl_next.div_zero   = (src_item.operand_b == '0);
    case (src_item.command)
      fdm_pkg::CMD_MAXIMUM: ctl_next.pass_value = a_less ? src_item.operand_b
                                                         : src_item.operand_a;
      fdm_pkg::CMD_MINIMUM: ctl_next.pass_value = a_less ? src_item.operand_a
                                                         : src_item.operand_b;
      default:              ctl_next.pass_value = '0;
    endcase
    div_next.rem     = '0;
    div_next.work    = src_item.operand_a[W-1] ? W'(-src_item.operand_a)
                                               : W'(src_item.operand_a);
    div_next.divisor = src_item.operand_b[W-1] ? W'(-src_item.operand_b)
                                               : W'(src_item.operand_b);
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= src_valid;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    stage_div <= div_next;
    stage_ctl <= ctl_next;
  end

endmodule

FILE: rtl/core/fdm_div_step.sv
// One restoring division step: produces one quotient bit per register stage.
// Depends on fdm_pkg.
module fdm_div_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  input  fdm_pkg::fdm_div_t src_div,
  input  fdm_pkg::fdm_ctl_t src_ctl,
  output logic              stage_valid,
  output fdm_pkg::fdm_div_t stage_div,
  output fdm_pkg::fdm_ctl_t stage_ctl
);

  localparam int W = fdm_pkg::DATA_WIDTH;

  logic [W:0]        trial;
  logic              fits;
  fdm_pkg::fdm_div_t div_next;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial            = {src_div.rem, src_div.work[W-1]} - {1'b0, src_div.divisor};
    fits             = ~trial[W];
    div_next.rem     = fits ? trial[W-1:0] : {src_div.rem[W-2:0], src_div.work[W-1]};
    div_next.work    = {src_div.work[W-2:0], fits};
    div_next.divisor = src_div.divisor;
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= src_valid;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    stage_div <= div_next;
    stage_ctl <= src_ctl;
  end

endmodule

FILE: rtl/core/fdm_finish.sv
// Back stages: floor/ceiling/modulo correction, sign restore, saturation and
// error coding. Depends on fdm_pkg.
module fdm_finish (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  input  fdm_pkg::fdm_div_t src_div,
  input  fdm_pkg::fdm_ctl_t src_ctl,
  output logic              done,
  output fdm_pkg::fdm_out_t result
);

  localparam int W = fdm_pkg::DATA_WIDTH;
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};

  logic              differ;
  logic              rem_nz;
  logic              bump;
  logic [W-1:0]      mod_mag;
  logic [W:0]        mag_next;
  logic              neg_next;

  logic              fix_valid;
  logic [W:0]        fix_mag;
  logic              fix_neg;
  fdm_pkg::fdm_ctl_t fix_ctl;

  logic              is_div;
  logic              overflow;
  fdm_pkg::fdm_out_t result_next;

  // Correct the magnitude: round quotient, fold remainder
  always_comb begin
    differ  = src_ctl.neg_a ^ src_ctl.neg_b;
    rem_nz  = (src_div.rem != '0);
    bump    = rem_nz && (((src_ctl.command == fdm_pkg::CMD_FLOOR_DIV) && differ) ||
                         ((src_ctl.command == fdm_pkg::CMD_CEIL_DIV) && !differ));
    mod_mag = !rem_nz ? '0 : (differ ? src_div.divisor - src_div.rem : src_div.rem);
    if (src_ctl.command == fdm_pkg::CMD_MODULO) begin
      mag_next = {1'b0, mod_mag};
      neg_next = src_ctl.neg_b;
    end else begin
      mag_next = {1'b0, src_div.work} + {{W{1'b0}}, bump};
      neg_next = differ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_valid <= 1'b0;
    end else begin
      fix_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    fix_mag <= mag_next;
    fix_neg <= neg_next;
    fix_ctl <= src_ctl;
  end

  // Restore the sign, saturate the one overflowing quotient, code errors
  always_comb begin
    is_div   = (fix_ctl.command == fdm_pkg::CMD_FLOOR_DIV) ||
               (fix_ctl.command == fdm_pkg::CMD_MODULO) ||
               (fix_ctl.command == fdm_pkg::CMD_CEIL_DIV);
    overflow = (fix_ctl.command != fdm_pkg::CMD_MODULO) && !fix_neg &&
               (fix_mag[W] || fix_mag[W-1]);
    if (!is_div) begin
      result_next.result_value = fix_ctl.pass_value;
      result_next.error_code   = fdm_pkg::ERR_OK;
    end else if (fix_ctl.div_zero) begin
      result_next.result_value = '0;
      result_next.error_code   = fdm_pkg::ERR_DIV_ZERO;
    end else if (overflow) begin
      result_next.result_value = MaxPos;
      result_next.error_code   = fdm_pkg::ERR_OVERFLOW;
    end else begin
      result_next.result_value = fix_neg ? -fix_mag[W-1:0] : fix_mag[W-1:0];
      result_next.error_code   = fdm_pkg::ERR_OK;
    end
  end

  // Strobe the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fix_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

FILE: rtl/core/fdm_checker.sv
// Port-level checker for floor_div_mod_unit, attached by bind below.
// Depends on fdm_pkg and floor_div_mod_unit_assert.svh.
`include "floor_div_mod_unit_assert.svh"

module fdm_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input fdm_pkg::fdm_in_t  operand,
  input logic              done,
  input fdm_pkg::fdm_out_t result
);

  localparam int Lat = fdm_pkg::LATENCY;
  localparam logic signed [fdm_pkg::DATA_WIDTH-1:0] MaxPos =
    {1'b0, {(fdm_pkg::DATA_WIDTH-1){1'b1}}};

  logic accepted;
  logic div_by_zero;

  assign accepted    = start && !busy;
  assign div_by_zero = accepted && (operand.command <= fdm_pkg::CMD_CEIL_DIV) &&
                       (operand.operand_b == '0);

  // Every transfer in gives exactly one result, a fixed time later
  `FDM_ASSERT_DELAY(a_result_follows, accepted, Lat, done)
  `FDM_ASSERT_DELAY(a_no_stray_result, !accepted, Lat, !done)
  // Division by zero reports its code and a zero value
  `FDM_ASSERT_DELAY(a_div_zero, div_by_zero, Lat,
                    result.error_code == fdm_pkg::ERR_DIV_ZERO && result.result_value == '0)
  // Overflow always comes with the saturated value
  `FDM_ASSERT_IMPLY(a_overflow_sat, done && result.error_code == fdm_pkg::ERR_OVERFLOW,
                    result.result_value == MaxPos)

endmodule

bind floor_div_mod_unit fdm_checker u_fdm_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .operand (operand),
  .done    (done),
  .result  (result)
);
